// ===== hdl/krke_pkg.sv =====
// krke_pkg: shared types and constants for the keyboard report to key event block
`timescale 1ns / 1ps

package krke_pkg;

   localparam int MAX_SLOTS       = 6;
   localparam int KEY_SLOTS_DFLT  = 6;
   localparam int MOD_BITS        = 8;
   localparam int USAGE_W         = 8;
   localparam int LENGTH_W        = 16;
   localparam logic [USAGE_W-1:0] MOD_BASE_USAGE = 8'hE0;

   localparam int REQ_DATA_W = LENGTH_W + MOD_BITS + MAX_SLOTS * USAGE_W;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic [MAX_SLOTS-1:0][USAGE_W-1:0] keys;
      logic [MOD_BITS-1:0]               mods;
   } report_type;

endpackage

// ===== hdl/krke_diff.sv =====
// krke_diff: compares a report with the held one and flags every event it causes
`timescale 1ns / 1ps

module krke_diff
   import krke_pkg::*;
#(
   parameter int KEY_SLOTS = KEY_SLOTS_DFLT
) (
   input  report_type                         cur,
   input  report_type                         prev,
   // modifier bits, then releases by slot, then presses by slot
   output logic [MOD_BITS+2*KEY_SLOTS-1:0]    event_mask
);

   logic [KEY_SLOTS-1:0] rel;
   logic [KEY_SLOTS-1:0] prs;

   always_comb begin
      logic held_in_cur;
      logic held_in_prev;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         held_in_cur  = 1'b0;
         held_in_prev = 1'b0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (cur.keys[j] == prev.keys[i]) begin
               held_in_cur = 1'b1;
            end
            if (prev.keys[j] == cur.keys[i]) begin
               held_in_prev = 1'b1;
            end
         end
         rel[i] = (prev.keys[i] != '0) && !held_in_cur;
         prs[i] = (cur.keys[i] != '0) && !held_in_prev;
      end
   end

   assign event_mask = {prs, rel, cur.mods ^ prev.mods};

endmodule

// ===== hdl/keyboard_report_to_key_events.sv =====
// keyboard_report_to_key_events: top level, turns boot keyboard reports into key events
//
// channel   direction  ports        content
// req       in         req_t*       one keyboard report per transfer
// rsp       out        rsp_t*       one key event per transfer, tlast on the final one
//
// a report passes an input register, then its events sit in an event buffer and
// leave through the output register at one transfer per cycle while rsp_tready holds
// the next report is taken while the final event of the previous one goes out
// a zero-length report or one with no changes gives no transfer on rsp
// synchronous reset clears the held modifiers and key slots and all valid flags
`timescale 1ns / 1ps

module keyboard_report_to_key_events
   import krke_pkg::*;
#(
   parameter int KEY_SLOTS = KEY_SLOTS_DFLT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // report_length, modifiers, key0, key1, key2, key3, key4, key5
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // usage, pressed, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int EV_N = MOD_BITS + 2 * KEY_SLOTS;

   logic                  s1_valid_ff, s1_valid_in;
   report_type            s1_rep_ff, s1_rep_in;
   report_type            prev_ff;
   logic [EV_N-1:0]       mask_ff, mask_in;
   report_type            buf_cur_ff, buf_prev_ff;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [USAGE_W-1:0]    usage_ff, usage_in;
   logic                  pressed_ff, pressed_in;
   logic                  last_ff, last_in;

   logic                  req_xfer;
   logic                  out_take;
   logic                  out_load;
   logic                  buf_free;
   logic                  s1_move;
   logic [EV_N-1:0]       new_mask;
   logic [EV_N-1:0]       pick;
   logic [EV_N-1:0][USAGE_W-1:0] cand_usage;
   logic [EV_N-1:0]       cand_pressed;

   krke_diff #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_diff (
      .cur        (s1_rep_ff),
      .prev       (prev_ff),
      .event_mask (new_mask)
   );

   assign req_xfer = req_tvalid && req_tready;
   assign out_take = !rsp_tvalid_ff || rsp_tready;
   assign out_load = (mask_ff != '0) && out_take;
   assign buf_free = (mask_ff == '0) || ($onehot(mask_ff) && out_take);
   assign s1_move  = s1_valid_ff && buf_free;
   assign req_tready = !s1_valid_ff || buf_free;

   // lowest pending event goes first
   assign pick = mask_ff & (~mask_ff + EV_N'(1));

   always_comb begin
      s1_rep_in.mods = req_tdata[LENGTH_W +: MOD_BITS];
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (i < KEY_SLOTS) begin
            s1_rep_in.keys[i] = req_tdata[LENGTH_W+MOD_BITS+i*USAGE_W +: USAGE_W];
         end else begin
            s1_rep_in.keys[i] = '0;
         end
      end
      // zero-length reports are dropped here
      if (req_xfer) begin
         s1_valid_in = (req_tdata[LENGTH_W-1:0] != '0);
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < MOD_BITS; i++) begin
         cand_usage[i]   = MOD_BASE_USAGE + USAGE_W'(i);
         cand_pressed[i] = buf_cur_ff.mods[i];
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         cand_usage[MOD_BITS+i]             = buf_prev_ff.keys[i];
         cand_pressed[MOD_BITS+i]           = 1'b0;
         cand_usage[MOD_BITS+KEY_SLOTS+i]   = buf_cur_ff.keys[i];
         cand_pressed[MOD_BITS+KEY_SLOTS+i] = 1'b1;
      end
      usage_in   = '0;
      pressed_in = 1'b0;
      for (int i = 0; i < EV_N; i++) begin
         if (pick[i]) begin
            usage_in   = usage_in | cand_usage[i];
            pressed_in = pressed_in | cand_pressed[i];
         end
      end
      last_in = ((mask_ff & ~pick) == '0);
   end

   always_comb begin
      mask_in = mask_ff;
      if (out_load) begin
         mask_in = mask_ff & ~pick;
      end
      if (s1_move) begin
         mask_in = new_mask;
      end
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         prev_ff       <= '0;
         mask_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         mask_ff       <= mask_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (s1_move) begin
            prev_ff <= s1_rep_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_rep_ff <= s1_rep_in;
      end
      if (s1_move) begin
         buf_cur_ff  <= s1_rep_ff;
         buf_prev_ff <= prev_ff;
      end
      if (out_load) begin
         usage_ff   <= usage_in;
         pressed_ff <= pressed_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-USAGE_W-1){1'b0}}, pressed_ff, usage_ff};
   assign rsp_tlast  = last_ff;

`ifndef ASSERT_OFF
   // held report changes only when a report moves into the event buffer
   a_prev_hold: assert property (@(posedge clock) disable iff (reset)
      (!s1_move && !reset) |=> $stable(prev_ff))
      else $error("held report changed without a report moving on");

   // an event that is not the final one leaves more events pending
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !last_ff) |-> (mask_ff != '0))
      else $error("non-final event with nothing pending");

   // pending events reach the output register
   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid_ff)
      else $error("pending event not loaded into output register");

   // buffer is only overwritten when empty or on its final event
   a_buf_free: assert property (@(posedge clock) disable iff (reset)
      s1_move |-> ((mask_ff == '0) || ($onehot(mask_ff) && out_take)))
      else $error("event buffer overwritten with events pending");
`endif

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for keyboard_report_to_key_events, directed table then random reports
`timescale 1ns / 1ps

module tb_top
   import krke_pkg::*;
();

   localparam int SLOTS          = KEY_SLOTS_DFLT;
   localparam int RANDOM_REPORTS = 390;
   localparam int PHASES         = 4;
   localparam int LONG_HOLD      = 400;
   localparam int STALL_LIMIT    = 4000;
   localparam int DRAIN_CYCLES   = 24;
   localparam int MAX_SHOWN      = 10;
   localparam int N_DIRECTED     = 20;

   localparam logic FROM_PREDICTOR = 1'b0;
   localparam logic TYPED          = 1'b1;

   typedef struct packed {
      logic               is_last;
      logic               pressed;
      logic [USAGE_W-1:0] usage;
   } key_event_type;

   typedef struct packed {
      logic [LENGTH_W-1:0]          len;
      logic [MOD_BITS-1:0]          mods;
      logic [MAX_SLOTS*USAGE_W-1:0] keys;      // key5 .. key0, key0 lowest
      logic                         typed;
      logic [1:0]                   n_typed;
      logic [1:0][9:0]              typed_ev;  // {is_last, pressed, usage}, first in [0]
   } stim_row_type;

   // typed events: 3xx press on the final event, 2xx release on the final event
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{16'h0000, 8'hFF, 48'hFFFF_FFFF_FFFF, TYPED,          2'd0, 20'h00000},
      '{16'h0001, 8'h01, 48'h0000_0000_0000, TYPED,          2'd1, 20'h003E0},
      '{16'hFFFF, 8'h00, 48'h0000_0000_0000, TYPED,          2'd1, 20'h002E0},
      '{16'h0001, 8'h80, 48'h0000_0000_0000, TYPED,          2'd1, 20'h003E7},
      '{16'h0002, 8'h7F, 48'h0000_0000_0000, FROM_PREDICTOR, 2'd0, 20'h00000},
      '{16'h0008, 8'hFF, 48'h0908_0706_0504, FROM_PREDICTOR, 2'd0, 20'h00000},
      '{16'h0008, 8'hFF, 48'h0908_0706_0504, TYPED,          2'd0, 20'h00000},
      '{16'h00FF, 8'h00, 48'hFAFB_FCFD_FEFF, FROM_PREDICTOR, 2'd0, 20'h00000},
      '{16'h00FF, 8'h00, 48'h0000_0000_1010, FROM_PREDICTOR, 2'd0, 20'h00000},
      '{16'h0001, 8'h00, 48'h0000_0000_1000, TYPED,          2'd0, 20'h00000},
      '{16'h0001, 8'h00, 48'h0101_0101_0101, FROM_PREDICTOR, 2'd0, 20'h00000},
      '{16'h0001, 8'h00, 48'h0303_0303_0302, FROM_PREDICTOR, 2'd0, 20'h00000},
      '{16'h0000, 8'hAA, 48'h1111_1111_1111, TYPED,          2'd0, 20'h00000},
      '{16'h8000, 8'h00, 48'h0000_0000_0000, FROM_PREDICTOR, 2'd0, 20'h00000},
      '{16'h0001, 8'h00, 48'h0000_0000_0000, TYPED,          2'd0, 20'h00000},
      '{16'h0001, 8'h00, 48'h0400_0000_0000, TYPED,          2'd1, 20'h00304},
      '{16'h0001, 8'h00, 48'h0000_0000_0000, TYPED,          2'd1, 20'h00204},
      '{16'h0001, 8'h55, 48'h2C2B_2A29_2827, FROM_PREDICTOR, 2'd0, 20'h00000},
      '{16'h0001, 8'hAA, 48'h2728_292A_2B2C, FROM_PREDICTOR, 2'd0, 20'h00000},
      '{16'h0001, 8'h00, 48'h0000_0000_0000, FROM_PREDICTOR, 2'd0, 20'h00000}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // report_length, modifiers, key0, key1, key2, key3, key4, key5
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // usage, pressed, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   report_type    held_report = '0;
   key_event_type pending_events [$];
   int            fail_count   = 0;
   int            tx_idle_pct  = 0;
   int            rx_stall_pct = 0;
   int            hold_asked   = 0;

   keyboard_report_to_key_events #(
      .KEY_SLOTS(SLOTS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit slot_has(input report_type r, input logic [USAGE_W-1:0] u);
      if (u == '0) return 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if (r.keys[i] == u) return 1'b1;
      return 1'b0;
   endfunction

   // works out the key events of one report and moves the held state on
   function automatic void predict_key_events(input logic [LENGTH_W-1:0] len,
                                              input report_type rpt, input bit keep);
      key_event_type ev [$];
      key_event_type tail;
      report_type    nxt;
      if (len == '0) return;
      nxt = rpt;
      for (int i = SLOTS; i < MAX_SLOTS; i++) nxt.keys[i] = '0;
      for (int b = 0; b < MOD_BITS; b++)
         if (nxt.mods[b] != held_report.mods[b])
            ev.push_back('{1'b0, nxt.mods[b], USAGE_W'(MOD_BASE_USAGE + b)});
      for (int i = 0; i < SLOTS; i++)
         if (held_report.keys[i] != '0 && !slot_has(nxt, held_report.keys[i]))
            ev.push_back('{1'b0, 1'b0, held_report.keys[i]});
      for (int i = 0; i < SLOTS; i++)
         if (nxt.keys[i] != '0 && !slot_has(held_report, nxt.keys[i]))
            ev.push_back('{1'b0, 1'b1, nxt.keys[i]});
      if (ev.size() > 0) begin
         tail = ev.pop_back();
         tail.is_last = 1'b1;
         ev.push_back(tail);
      end
      if (keep)
         foreach (ev[j]) pending_events.push_back(ev[j]);
      held_report = nxt;
   endfunction

   // one report transfer, with random idle cycles ahead of it
   task automatic offer_report(input logic [REQ_DATA_W-1:0] word);
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin : sink
      int hold_left;
      int hold_done;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_done != hold_asked) begin
            hold_done++;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_events
      key_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display("unexpected event: tdata %h tlast %b", rsp_tdata, rsp_tlast);
         end else begin
            want = pending_events.pop_front();
            if (rsp_tdata !== RSP_DATA_W'({want.pressed, want.usage}) ||
                rsp_tlast !== want.is_last) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display({"event mismatch: expected usage %h pressed %b last %b, ",
                            "got tdata %h tlast %b"},
                           want.usage, want.pressed, want.is_last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type        row;
      report_type          cur;
      logic [LENGTH_W-1:0] len;
      int                  counted;
      int                  pick;
      int                  bit_pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         offer_report({row.keys, row.mods, row.len});
         predict_key_events(row.len, report_type'({row.keys, row.mods}), !row.typed);
         if (row.typed)
            for (int j = 0; j < row.n_typed; j++)
               pending_events.push_back(key_event_type'(row.typed_ev[j]));
      end

      cur = held_report;
      for (int p = 0; p < PHASES; p++) begin
         tx_idle_pct  = (p == 1) ? 67 : (p == 3) ? 37 : 0;
         rx_stall_pct = (p == 2) ? 67 : (p == 3) ? 37 : 0;
         counted = 0;
         while (counted < (RANDOM_REPORTS + PHASES - 1) / PHASES) begin
            // long receiver hold-off so the event buffer fills and the input stalls
            if (p == 0 && counted == 40 && hold_asked == 0) hold_asked++;
            pick = $urandom_range(99);
            if (pick < 20) begin
               cur.mods = MOD_BITS'($urandom);
               for (int i = 0; i < MAX_SLOTS; i++)
                  cur.keys[i] = ($urandom_range(99) < 30) ? '0 : USAGE_W'($urandom);
            end else begin
               // typing: a modifier flips now and then, a few slots change
               if ($urandom_range(1) == 1) begin
                  bit_pick = $urandom_range(MOD_BITS - 1);
                  cur.mods[bit_pick] = ~cur.mods[bit_pick];
               end
               for (int i = 0; i < MAX_SLOTS; i++)
                  if ($urandom_range(99) < 25) begin
                     pick = $urandom_range(9);
                     if (pick < 5)
                        cur.keys[i] = '0;
                     else if (pick < 9)
                        cur.keys[i] = USAGE_W'($urandom_range(4, 11));
                     else
                        cur.keys[i] = USAGE_W'($urandom);
                  end
            end
            pick = $urandom_range(15);
            if (pick == 0)
               len = '0;
            else if (pick < 8)
               len = LENGTH_W'($urandom_range(1, 8));
            else
               len = LENGTH_W'($urandom_range(1, 65535));
            offer_report({cur.keys, cur.mods, len});
            predict_key_events(len, cur, 1'b1);
            cur = held_report;
            counted++;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/krke_pkg.sv
hdl/krke_diff.sv
hdl/keyboard_report_to_key_events.sv
tb/tb_top.sv
